### rtl/bcep_pkg.sv
// Shared types and constants for the edge-pixel binarizer and counter.
// No dependencies.
`default_nettype none

package bcep_pkg;

    // Default largest frame dimension (pixels per row, rows per frame)
    localparam int unsigned MAX_DIMENSION_DEF = 2048;

    // Configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned CFG_DIM_W  = 12;
    localparam int unsigned CFG_FMT_W  = 2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_IMAGE_WIDTH  = 2'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT = 2'd1;
    localparam t_reg_idx REG_PIXEL_FORMAT = 2'd2;

    localparam logic [CFG_FMT_W-1:0] FMT_GRAY = 2'd2;

    // Pixel payload
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned SUM_W  = 10;
    localparam logic [SUM_W-1:0] PRESENCE_THRESHOLD = 10'd384;

    // Edge counter, saturating
    localparam int unsigned CNT_W = 23;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // One line store entry: presence bit of the row above and of the row two above
    typedef struct packed {
        logic above;
        logic two_above;
    } t_line_bits;

endpackage

`default_nettype wire

### rtl/bcep_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module bcep_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd0_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd0_addr,
    output logic      [WIDTH-1:0]         o_rd0_data,
    input  wire logic                     i_rd1_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd1_addr,
    output logic      [WIDTH-1:0]         o_rd1_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd0_en) begin
            o_rd0_data <= r_mem[i_rd0_addr];
        end
        if (i_rd1_en) begin
            o_rd1_data <= r_mem[i_rd1_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/binarize_and_count_edge_pixels.sv
// Pipeline: stage 1 register (with the line store read), then the result register.
// Throughput: one pixel per cycle while o_stall is low (two-read line store RAM).
// Reset (synchronous, active low) clears position, counter and configuration, then runs a
// line store clearing pass over all MAX_DIMENSION entries (2048 by default) with o_stall high;
// configuration writes are taken during the pass.
// Depends on bcep_pkg and bcep_ram.
`default_nettype none

module binarize_and_count_edge_pixels #(
    parameter int unsigned MAX_DIMENSION = bcep_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bcep_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [bcep_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [bcep_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    // pixel input
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [bcep_pkg::CHAN_W-1:0]         i_red_or_gray,
    input  wire logic [bcep_pkg::CHAN_W-1:0]         i_green,
    input  wire logic [bcep_pkg::CHAN_W-1:0]         i_blue,
    // result output
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_pixel_present,
    output logic                                     o_edge_judged,
    output logic                                     o_edge_found,
    output logic      [bcep_pkg::CNT_W-1:0]          o_edge_total,
    output logic                                     o_frame_end
);

    import bcep_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_DIMENSION);
    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int unsigned CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam int unsigned LB_W  = $bits(t_line_bits);

    // ---------------- configuration ----------------
    logic [CFG_DIM_W-1:0] r_image_width;
    logic [CFG_DIM_W-1:0] r_image_height;
    logic [CFG_FMT_W-1:0] r_pixel_format;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_DIM_W'(MAX_DIMENSION_DEF);
            r_image_height <= CFG_DIM_W'(MAX_DIMENSION_DEF);
            r_pixel_format <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_DIM_W-1:0];
                REG_PIXEL_FORMAT: r_pixel_format <= pwdata[CFG_FMT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            REG_PIXEL_FORMAT: prdata = APB_DATA_W'(r_pixel_format);
            default:          prdata = '0;
        endcase
    end

    // clamp sizes to 1..MAX_DIMENSION
    logic [CMP_W-1:0] width_ext, height_ext;
    logic [DIM_W-1:0] width, height;

    always_comb begin
        width_ext  = CMP_W'(r_image_width);
        height_ext = CMP_W'(r_image_height);
        if (width_ext == '0) begin
            width = DIM_W'(1);
        end else if (width_ext > CMP_W'(MAX_DIMENSION)) begin
            width = DIM_W'(MAX_DIMENSION);
        end else begin
            width = width_ext[DIM_W-1:0];
        end
        if (height_ext == '0) begin
            height = DIM_W'(1);
        end else if (height_ext > CMP_W'(MAX_DIMENSION)) begin
            height = DIM_W'(MAX_DIMENSION);
        end else begin
            height = height_ext[DIM_W-1:0];
        end
    end

    // ---------------- control / handshake ----------------
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic             s1_adv, s1_leave, accept;

    assign s1_adv   = !r_out_valid || !i_stall;
    assign s1_leave = r_s1_valid && s1_adv;
    assign o_stall  = r_clr_busy || (r_s1_valid && !s1_adv);
    assign accept   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(MAX_DIMENSION - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- position (at accept) ----------------
    logic [IDX_W-1:0] r_col, r_row;
    logic [IDX_W-1:0] n_col, n_row;
    logic             wrap_col, new_frame, col_last, row_last, judged;
    logic [DIM_W-1:0] y_pre, x_ext, y_ext;
    logic [IDX_W-1:0] cur_x, cur_y, next_x;

    always_comb begin
        wrap_col  = DIM_W'(r_col) >= width;
        cur_x     = wrap_col ? '0 : r_col;
        y_pre     = wrap_col ? DIM_W'(r_row) + DIM_W'(1) : DIM_W'(r_row);
        new_frame = y_pre >= height;
        cur_y     = new_frame ? '0 : y_pre[IDX_W-1:0];
        x_ext     = DIM_W'(cur_x);
        y_ext     = DIM_W'(cur_y);
        col_last  = (x_ext + DIM_W'(1)) >= width;
        row_last  = (y_ext + DIM_W'(1)) >= height;
        next_x    = IDX_W'(x_ext + DIM_W'(1));
        judged    = (y_ext >= DIM_W'(2)) && (width >= DIM_W'(3)) &&
                    (cur_x != '0) && !col_last;
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : IDX_W'(y_ext + DIM_W'(1));
        end else begin
            n_col = next_x;
            n_row = cur_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1 registers ----------------
    logic [CHAN_W-1:0] r_s1_r, r_s1_g, r_s1_b;
    logic [IDX_W-1:0]  r_s1_x, r_s1_x1;
    logic              r_s1_judged, r_s1_last, r_s1_new_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_r         <= i_red_or_gray;
            r_s1_g         <= i_green;
            r_s1_b         <= i_blue;
            r_s1_x         <= cur_x;
            r_s1_x1        <= next_x;
            r_s1_judged    <= judged;
            r_s1_last      <= col_last && row_last;
            r_s1_new_frame <= new_frame;
        end
    end

    // ---------------- line store ----------------
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_line_bits       wr_data, rd0_raw, rd1_raw, ent_x, ent_x1;
    logic [LB_W-1:0]  rd0_bits, rd1_bits;
    logic [IDX_W-1:0] r_wr_addr;
    t_line_bits       r_wr_data;
    logic             r_prev_a;

    bcep_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_DIMENSION)
    ) u_line_ram (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd0_en   (accept),
        .i_rd0_addr (cur_x),
        .o_rd0_data (rd0_bits),
        .i_rd1_en   (accept),
        .i_rd1_addr (next_x),
        .o_rd1_data (rd1_bits)
    );

    assign rd0_raw = rd0_bits;
    assign rd1_raw = rd1_bits;

    // a write on the edge of the read is not seen by the RAM: forward the last write
    assign ent_x  = (r_wr_addr == r_s1_x)  ? r_wr_data : rd0_raw;
    assign ent_x1 = (r_wr_addr == r_s1_x1) ? r_wr_data : rd1_raw;

    // ---------------- stage 1 logic ----------------
    logic [SUM_W-1:0] sum;
    logic             present, found, inc;
    logic [CNT_W-1:0] r_cnt, cnt_base, total;

    always_comb begin
        if (r_pixel_format == FMT_GRAY) begin
            sum = {1'b0, r_s1_r, 1'b0} + SUM_W'(r_s1_r);
        end else begin
            sum = SUM_W'(r_s1_r) + SUM_W'(r_s1_g) + SUM_W'(r_s1_b);
        end
        present  = sum > PRESENCE_THRESHOLD;
        // left: row above at x-1 (carried from the previous beat), right: row above at x+1,
        // up: row two above at x, down: this pixel
        found    = r_s1_judged && ((r_prev_a != ent_x1.above) ||
                                   (ent_x.two_above != present));
        cnt_base = r_s1_new_frame ? '0 : r_cnt;
        inc      = found && (cnt_base != CNT_MAX);
        total    = cnt_base + CNT_W'(inc);
    end

    always_comb begin
        wr_en             = r_clr_busy || s1_leave;
        wr_addr           = r_clr_busy ? r_clr_addr : r_s1_x;
        wr_data.above     = r_clr_busy ? 1'b0 : present;
        wr_data.two_above = r_clr_busy ? 1'b0 : ent_x.above;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wr_addr <= wr_addr;
            r_wr_data <= wr_data;
        end
        if (s1_leave) begin
            r_prev_a <= ent_x.above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s1_leave) begin
            r_cnt <= r_s1_last ? '0 : total;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_leave) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            o_pixel_present <= present;
            o_edge_judged   <= r_s1_judged;
            o_edge_found    <= found;
            o_edge_total    <= total;
            o_frame_end     <= r_s1_last;
        end
    end

    // ---------------- assertions ----------------
    a_found_needs_judged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_edge_found) |-> o_edge_judged)
        else $error("edge_found without edge_judged");

    a_found_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_edge_found) |-> (o_edge_total != '0))
        else $error("edge found but total is zero");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_valid && !r_out_valid))
        else $error("pixel in flight during line store clear");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |=> (r_s1_valid && $stable(r_s1_x)))
        else $error("stage 1 beat lost under output stall");

endmodule

`default_nettype wire
